// ----- rtl/core/dfa_edge_table_acceptor_assert.svh -----
// Assertion macros used by the acceptor sequencer.
`ifndef DFA_EDGE_TABLE_ACCEPTOR_ASSERT_SVH
`define DFA_EDGE_TABLE_ACCEPTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFAET_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFAET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dfaet_pkg.sv -----
package dfaet_pkg;

  // Fixed field widths of the command and result transactions.
  localparam int unsigned StateW  = 8;
  localparam int unsigned LetterW = 8;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_EDGE   = 2'd0,
    CMD_FINAL  = 2'd1,
    CMD_LETTER = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Register select, taken from paddr bit 2.
  typedef enum logic {
    REG_START = 1'b0,
    REG_COUNT = 1'b1
  } reg_e;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } seq_state_e;

  // Configuration handed from the register block to the sequencer.
  typedef struct packed {
    logic              start_wr;
    logic [StateW-1:0] start_state;
    logic [CountW-1:0] edge_count;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    logic              alive;
    logic              word_done;
    logic              accepted;
    logic [StateW-1:0] current;
  } res_t;

endpackage

// ----- rtl/core/dfaet_edge_mem.sv -----
module dfaet_edge_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 24
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Single registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/dfaet_seq.sv -----
`include "dfa_edge_table_acceptor_assert.svh"

module dfaet_seq #(
  parameter int unsigned MaxEdges   = 1024,
  parameter int unsigned MaxStates  = 256,
  parameter int unsigned LetterBits = 8,
  parameter int unsigned EdgeAddrW  = 10,
  parameter int unsigned EntryW     = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dfaet_pkg::cfg_t               cfg_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command_i,
  input  logic [dfaet_pkg::IndexW-1:0]  edge_index_i,
  input  logic [dfaet_pkg::StateW-1:0]  source_state_i,
  input  logic [dfaet_pkg::LetterW-1:0] edge_letter_i,
  input  logic [dfaet_pkg::StateW-1:0]  target_state_i,
  input  logic                          final_mark_i,
  input  logic                          last_letter_i,
  output logic                          res_valid_o,
  output dfaet_pkg::res_t               res_o,
  output logic                          mem_we_o,
  output logic [EdgeAddrW-1:0]          mem_waddr_o,
  output logic [EntryW-1:0]             mem_wdata_o,
  output logic                          mem_re_o,
  output logic [EdgeAddrW-1:0]          mem_raddr_o,
  input  logic [EntryW-1:0]             mem_rdata_i
);

  localparam int unsigned SW    = dfaet_pkg::StateW;
  localparam int unsigned LB    = (LetterBits < dfaet_pkg::LetterW) ? LetterBits
                                                                   : dfaet_pkg::LetterW;
  localparam int unsigned CW    = $clog2(MaxEdges + 1);
  localparam int unsigned NW    = (CW > dfaet_pkg::CountW) ? CW : dfaet_pkg::CountW;
  localparam int unsigned IXW   = ((EdgeAddrW > dfaet_pkg::IndexW) ? EdgeAddrW
                                                                    : dfaet_pkg::IndexW) + 1;
  localparam int unsigned FD    = (MaxStates < 256) ? MaxStates : 256;
  localparam int unsigned FW    = $clog2(FD);

  dfaet_pkg::seq_state_e state_q, state_d;
  logic [CW-1:0]         addr_q;
  logic                  pend_q;
  logic [LB-1:0]         letter_q;
  logic                  last_q;
  logic [SW-1:0]         present_q;
  logic                  dead_q;
  logic [FD-1:0]         flags_q;
  logic                  res_valid_q;
  dfaet_pkg::res_t       res_q;

  logic                  accept;
  logic                  is_letter;
  logic                  quick;
  logic [NW-1:0]         cnt_ext;
  logic [NW-1:0]         n_wide;
  logic [CW-1:0]         n_lim;
  logic [IXW-1:0]        idx_ext;
  logic                  idx_ok;
  logic                  src_ok;
  logic [SW-1:0]         rd_src;
  logic [LB-1:0]         rd_sym;
  logic [SW-1:0]         rd_dst;
  logic                  match;
  logic                  issue;
  logic                  scan_end;
  logic [SW-1:0]         next_present;
  logic                  next_final;

  // Handshake and command decode.
  assign accept    = start && (state_q == dfaet_pkg::ST_IDLE);
  assign busy      = (state_q != dfaet_pkg::ST_IDLE);
  assign is_letter = (command_i == dfaet_pkg::CMD_LETTER);
  assign quick     = accept && !(is_letter && !dead_q);

  // Scan length: edge_count clamped to the table depth.
  assign cnt_ext = NW'(cfg_i.edge_count);
  assign n_wide  = (cnt_ext > NW'(MaxEdges)) ? NW'(MaxEdges) : cnt_ext;
  assign n_lim   = n_wide[CW-1:0];

  // Edge table write on an edge command.
  assign idx_ext     = IXW'(edge_index_i);
  assign idx_ok      = idx_ext < IXW'(MaxEdges);
  assign mem_we_o    = accept && (command_i == dfaet_pkg::CMD_EDGE) && idx_ok;
  assign mem_waddr_o = idx_ext[EdgeAddrW-1:0];
  assign mem_wdata_o = {source_state_i, edge_letter_i[LB-1:0], target_state_i};

  // Shared compare unit: one table entry is checked per cycle.
  assign rd_src = mem_rdata_i[EntryW-1 -: SW];
  assign rd_sym = mem_rdata_i[SW +: LB];
  assign rd_dst = mem_rdata_i[SW-1:0];
  assign match  = pend_q && (rd_src == present_q) && (rd_sym == letter_q);

  // Read issue and scan termination.
  assign issue       = (state_q == dfaet_pkg::ST_SCAN) && !match && (addr_q < n_lim);
  assign scan_end    = (state_q == dfaet_pkg::ST_SCAN) &&
                       (match || (!pend_q && (addr_q >= n_lim)));
  assign mem_re_o    = issue;
  assign mem_raddr_o = addr_q[EdgeAddrW-1:0];

  // State reached and its final flag.
  assign next_present = match ? rd_dst : present_q;
  assign next_final   = ({1'b0, next_present} < (SW + 1)'(FD)) ?
                        flags_q[next_present[FW-1:0]] : 1'b0;
  assign src_ok       = {1'b0, source_state_i} < (SW + 1)'(FD);

  // Sequencer state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dfaet_pkg::ST_IDLE: begin
        if (accept && is_letter && !dead_q) begin
          state_d = dfaet_pkg::ST_SCAN;
        end
      end
      dfaet_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = dfaet_pkg::ST_IDLE;
        end
      end
      default: state_d = dfaet_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfaet_pkg::ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= issue;
    end
  end

  // Scan address and the latched letter.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q   <= '0;
      letter_q <= edge_letter_i[LB-1:0];
      last_q   <= last_letter_i;
    end else if (issue) begin
      addr_q <= CW'(addr_q + 1'b1);
    end
  end

  // Present state and dead flag; a start_state write aborts the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      dead_q    <= 1'b0;
    end else if (cfg_i.start_wr) begin
      present_q <= cfg_i.start_state;
      dead_q    <= 1'b0;
    end else if (scan_end) begin
      if (last_q) begin
        present_q <= cfg_i.start_state;
        dead_q    <= 1'b0;
      end else begin
        present_q <= next_present;
        dead_q    <= !match;
      end
    end else if (accept && is_letter && dead_q && last_letter_i) begin
      present_q <= cfg_i.start_state;
      dead_q    <= 1'b0;
    end
  end

  // Final flags, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (accept && (command_i == dfaet_pkg::CMD_FINAL) && src_ok) begin
      flags_q[source_state_i[FW-1:0]] <= final_mark_i;
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= quick || scan_end;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (scan_end) begin
      res_q.alive     <= match;
      res_q.word_done <= last_q;
      res_q.accepted  <= last_q && match && next_final;
      res_q.current   <= next_present;
    end else if (quick) begin
      res_q.alive     <= !dead_q;
      res_q.word_done <= is_letter && last_letter_i;
      res_q.accepted  <= 1'b0;
      res_q.current   <= present_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A closed word is accepted only if it stayed alive.
  `DFAET_ASSERT_SAME(a_acc_alive, res_valid_q && res_q.accepted,
                     res_q.word_done && res_q.alive, "accepted word not alive or not closed")
  // A live letter always starts a table scan.
  `DFAET_ASSERT_NEXT(a_letter_scans, accept && is_letter && !dead_q,
                     state_q == dfaet_pkg::ST_SCAN, "live letter did not start a scan")
  // Every other transaction answers in the next cycle.
  `DFAET_ASSERT_NEXT(a_quick_result, quick, res_valid_q, "missing one-cycle result")
  // No result is shown while a scan is in progress.
  `DFAET_ASSERT_SAME(a_scan_quiet, state_q == dfaet_pkg::ST_SCAN, !res_valid_q,
                     "result strobe during scan")
  // Closing a word restarts from the start state, alive.
  `DFAET_ASSERT_SAME(a_restart, res_valid_q && res_q.word_done,
                     !dead_q && (present_q == cfg_i.start_state), "word did not restart")

endmodule

// ----- rtl/core/dfa_edge_table_acceptor.sv -----
// Edge, final-flag and unused commands, and letters on a dead word: result strobe in
// the cycle after start is taken. A letter on a live word scans the table from entry 0
// to the first match or over n entries, n = edge_count clamped to MAX_EDGES.
// One table entry per cycle; busy stays high during the scan; next start in strobe cycle.
// Reset clears registers, final flags, state (to 0) and the dead flag; the edge table
// is not cleared. Results cannot be stalled by the receiver.
module dfa_edge_table_acceptor #(
  parameter int unsigned MAX_EDGES   = 1024,
  parameter int unsigned MAX_STATES  = 256,
  parameter int unsigned LETTER_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfaet_pkg::PaddrW-1:0]  paddr,
  input  logic [dfaet_pkg::PdataW-1:0]  pwdata,
  output logic [dfaet_pkg::PdataW-1:0]  prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command_i,
  input  logic [dfaet_pkg::IndexW-1:0]  edge_index_i,
  input  logic [dfaet_pkg::StateW-1:0]  source_state_i,
  input  logic [dfaet_pkg::LetterW-1:0] edge_letter_i,
  input  logic [dfaet_pkg::StateW-1:0]  target_state_i,
  input  logic                          final_mark_i,
  input  logic                          last_letter_i,
  output logic                          result_valid_o,
  output logic                          alive_o,
  output logic                          word_done_o,
  output logic                          accepted_o,
  output logic [dfaet_pkg::StateW-1:0]  current_o
);

  localparam int unsigned LB        = (LETTER_BITS < dfaet_pkg::LetterW) ? LETTER_BITS
                                                                          : dfaet_pkg::LetterW;
  localparam int unsigned EdgeAddrW = $clog2(MAX_EDGES);
  localparam int unsigned EntryW    = 2 * dfaet_pkg::StateW + LB;

  logic [dfaet_pkg::StateW-1:0] start_q;
  logic [dfaet_pkg::CountW-1:0] count_q;
  logic                         wr;
  dfaet_pkg::cfg_t              cfg;
  dfaet_pkg::res_t              res;
  logic                         mem_we;
  logic [EdgeAddrW-1:0]         mem_waddr;
  logic [EntryW-1:0]            mem_wdata;
  logic                         mem_re;
  logic [EdgeAddrW-1:0]         mem_raddr;
  logic [EntryW-1:0]            mem_rdata;

  // Register write transaction; the port never waits.
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      count_q <= '0;
    end else if (wr) begin
      unique case (paddr[2])
        dfaet_pkg::REG_START: start_q <= pwdata[dfaet_pkg::StateW-1:0];
        dfaet_pkg::REG_COUNT: count_q <= pwdata[dfaet_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      dfaet_pkg::REG_START: prdata = dfaet_pkg::PdataW'(start_q);
      dfaet_pkg::REG_COUNT: prdata = dfaet_pkg::PdataW'(count_q);
      default:              prdata = '0;
    endcase
  end

  // A start state write hands its new value over in the same cycle.
  assign cfg.start_wr    = wr && (paddr[2] == dfaet_pkg::REG_START);
  assign cfg.start_state = cfg.start_wr ? pwdata[dfaet_pkg::StateW-1:0] : start_q;
  assign cfg.edge_count  = count_q;

  // Command sequencer with the shared entry compare.
  dfaet_seq #(
    .MaxEdges   (MAX_EDGES),
    .MaxStates  (MAX_STATES),
    .LetterBits (LETTER_BITS),
    .EdgeAddrW  (EdgeAddrW),
    .EntryW     (EntryW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .edge_index_i   (edge_index_i),
    .source_state_i (source_state_i),
    .edge_letter_i  (edge_letter_i),
    .target_state_i (target_state_i),
    .final_mark_i   (final_mark_i),
    .last_letter_i  (last_letter_i),
    .res_valid_o    (result_valid_o),
    .res_o          (res),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  // Edge table.
  dfaet_edge_mem #(
    .Depth (MAX_EDGES),
    .AddrW (EdgeAddrW),
    .DataW (EntryW)
  ) u_edge_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign alive_o     = res.alive;
  assign word_done_o = res.word_done;
  assign accepted_o  = res.accepted;
  assign current_o   = res.current;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned EDGE_SLOTS   = 1024;
  localparam int unsigned STATE_SLOTS  = 256;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned LIVE_CAP     = 64;
  localparam int unsigned TAIL_CYCLES  = EDGE_SLOTS + 8;
  localparam int unsigned RUN_LIMIT_NS = 60_000_000;

  // One command transaction as presented on the payload ports.
  typedef struct {
    dfaet_pkg::cmd_e cmd;
    bit [9:0]        idx;
    bit [7:0]        src;
    bit [7:0]        sym;
    bit [7:0]        dst;
    bit              mark;
    bit              last;
  } cmd_item_t;

  // One row of the directed stimulus: a register write or a command.
  typedef struct {
    bit              is_cfg;
    dfaet_pkg::reg_e sel;
    logic [31:0]     value;
    cmd_item_t       item;
    bit              typed;
    dfaet_pkg::res_t want;
  } stim_row_t;

  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                psel           = 1'b0;
  logic                                penable        = 1'b0;
  logic                                pwrite         = 1'b0;
  logic [dfaet_pkg::PaddrW-1:0]        paddr          = '0;
  logic [dfaet_pkg::PdataW-1:0]        pwdata         = '0;
  logic [dfaet_pkg::PdataW-1:0]        prdata;
  logic                                pready;
  logic                                start          = 1'b0;
  logic                                busy;
  logic [1:0]                          command_i      = '0;
  logic [dfaet_pkg::IndexW-1:0]        edge_index_i   = '0;
  logic [dfaet_pkg::StateW-1:0]        source_state_i = '0;
  logic [dfaet_pkg::LetterW-1:0]       edge_letter_i  = '0;
  logic [dfaet_pkg::StateW-1:0]        target_state_i = '0;
  logic                                final_mark_i   = 1'b0;
  logic                                last_letter_i  = 1'b0;
  logic                                result_valid_o;
  logic                                alive_o;
  logic                                word_done_o;
  logic                                accepted_o;
  logic [dfaet_pkg::StateW-1:0]        current_o;

  // Shadow copy of the automaton: edge table, final flags, registers and word status.
  bit [7:0]  edge_src     [EDGE_SLOTS];
  bit [7:0]  edge_sym     [EDGE_SLOTS];
  bit [7:0]  edge_dst     [EDGE_SLOTS];
  bit        entry_loaded [EDGE_SLOTS];
  bit        final_flag   [STATE_SLOTS];
  bit [7:0]  start_q;
  bit [10:0] edge_count_q;
  bit [7:0]  present_q;
  bit        word_dead_q;

  // Results still owed by the block, oldest first.
  dfaet_pkg::res_t verdict_q [$];
  stim_row_t       directed_rows [$];
  bit [7:0]        state_pool [4];
  bit [7:0]        letter_pool [3];
  bit              calm_stretch;
  int unsigned     mismatch_cnt;

  dfa_edge_table_acceptor u_dut (.*);

  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(string what);
    mismatch_cnt++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Advance the shadow automaton by one accepted transaction and return its result.
  function automatic dfaet_pkg::res_t run_automaton(cmd_item_t it);
    dfaet_pkg::res_t r;
    int unsigned     span;
    int unsigned     e;
    bit              hit;
    r = '0;
    case (it.cmd)
      dfaet_pkg::CMD_EDGE: begin
        edge_src[it.idx]     = it.src;
        edge_sym[it.idx]     = it.sym;
        edge_dst[it.idx]     = it.dst;
        entry_loaded[it.idx] = 1'b1;
      end
      dfaet_pkg::CMD_FINAL: begin
        final_flag[it.src] = it.mark;
      end
      dfaet_pkg::CMD_LETTER: begin
        // First matching edge in table order wins; no match kills the word.
        if (!word_dead_q) begin
          span = (edge_count_q > EDGE_SLOTS) ? EDGE_SLOTS : int'(edge_count_q);
          hit  = 1'b0;
          for (e = 0; e < span && !hit; e++) begin
            if (edge_src[e] == present_q && edge_sym[e] == it.sym) begin
              present_q = edge_dst[e];
              hit       = 1'b1;
            end
          end
          if (!hit) word_dead_q = 1'b1;
        end
        if (it.last) begin
          r.word_done = 1'b1;
          r.accepted  = !word_dead_q && final_flag[present_q];
        end
      end
      default: ;
    endcase
    r.alive   = !word_dead_q;
    r.current = present_q;
    // A closed word restarts alive from the start state.
    if (r.word_done) begin
      present_q   = start_q;
      word_dead_q = 1'b0;
    end
    return r;
  endfunction

  function automatic int unsigned loaded_prefix();
    int unsigned n;
    n = 0;
    while (n < EDGE_SLOTS && entry_loaded[n]) n++;
    return n;
  endfunction

  // An edge write whose endpoints and letter come from the current pools.
  function automatic cmd_item_t pool_edge(bit [9:0] idx);
    cmd_item_t it;
    it.cmd  = dfaet_pkg::CMD_EDGE;
    it.idx  = idx;
    it.src  = state_pool[$urandom_range(0, 3)];
    it.sym  = letter_pool[$urandom_range(0, 2)];
    it.dst  = state_pool[$urandom_range(0, 3)];
    it.mark = 1'($urandom);
    it.last = 1'($urandom);
    return it;
  endfunction

  // Mostly a letter that leaves the present state along a live edge.
  function automatic bit [7:0] pick_letter();
    int unsigned span;
    int unsigned hits;
    int unsigned e;
    bit [7:0]    picked;
    span   = (edge_count_q > EDGE_SLOTS) ? EDGE_SLOTS : int'(edge_count_q);
    hits   = 0;
    picked = ($urandom_range(0, 99) < 60) ? letter_pool[$urandom_range(0, 2)]
                                          : 8'($urandom);
    if ($urandom_range(0, 99) < 75) begin
      for (e = 0; e < span; e++) begin
        if (edge_src[e] == present_q) begin
          hits++;
          if ($urandom_range(1, hits) == 1) picked = edge_sym[e];
        end
      end
    end
    return picked;
  endfunction

  function automatic cmd_item_t random_command();
    cmd_item_t   it;
    int unsigned roll;
    int unsigned span;
    it.cmd  = dfaet_pkg::CMD_NOP;
    it.idx  = 10'($urandom);
    it.src  = 8'($urandom);
    it.sym  = 8'($urandom);
    it.dst  = 8'($urandom);
    it.mark = 1'($urandom);
    it.last = 1'($urandom);
    roll    = $urandom_range(0, 99);
    span    = (edge_count_q > EDGE_SLOTS) ? EDGE_SLOTS : int'(edge_count_q);
    if (roll < 14) begin
      it = pool_edge((span != 0 && $urandom_range(0, 99) < 85) ?
                     10'($urandom_range(0, span - 1)) : 10'($urandom));
      if ($urandom_range(0, 4) == 0) it.sym = 8'($urandom);
    end else if (roll < 22) begin
      it.cmd = dfaet_pkg::CMD_FINAL;
      if ($urandom_range(0, 99) < 80) it.src = state_pool[$urandom_range(0, 3)];
    end else if (roll >= 25) begin
      it.cmd  = dfaet_pkg::CMD_LETTER;
      it.sym  = pick_letter();
      it.last = ($urandom_range(0, 3) == 0);
    end
    return it;
  endfunction

  // A letter along the pool ring, or now and then a final flag on a pool state.
  function automatic cmd_item_t ring_command();
    cmd_item_t it;
    it = pool_edge(10'd0);
    if ($urandom_range(0, 3) == 0) begin
      it.cmd = dfaet_pkg::CMD_FINAL;
    end else begin
      it.cmd  = dfaet_pkg::CMD_LETTER;
      it.sym  = letter_pool[0];
      it.last = ($urandom_range(0, 2) == 0);
    end
    return it;
  endfunction

  function automatic void add_cmd(dfaet_pkg::cmd_e cmd, bit [9:0] idx, bit [7:0] src,
                                  bit [7:0] sym, bit [7:0] dst, bit mark, bit last,
                                  bit typed, dfaet_pkg::res_t want);
    stim_row_t row;
    row.is_cfg    = 1'b0;
    row.sel       = dfaet_pkg::REG_START;
    row.value     = '0;
    row.item.cmd  = cmd;
    row.item.idx  = idx;
    row.item.src  = src;
    row.item.sym  = sym;
    row.item.dst  = dst;
    row.item.mark = mark;
    row.item.last = last;
    row.typed     = typed;
    row.want      = want;
    directed_rows = {directed_rows, row};
  endfunction

  function automatic void add_cfg(dfaet_pkg::reg_e sel, logic [31:0] value);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.sel    = sel;
    row.value  = value;
    row.typed  = 1'b0;
    row.want   = '0;
    directed_rows = {directed_rows, row};
  endfunction

  // Present one command, wait for the handshake and record what it should produce.
  task automatic issue_command(cmd_item_t it, bit typed, dfaet_pkg::res_t want);
    dfaet_pkg::res_t model_res;
    int unsigned     gap;
    if (!calm_stretch && $urandom_range(0, 99) < 27) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    command_i      <= it.cmd;
    edge_index_i   <= it.idx;
    source_state_i <= it.src;
    edge_letter_i  <= it.sym;
    target_state_i <= it.dst;
    final_mark_i   <= it.mark;
    last_letter_i  <= it.last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    model_res = run_automaton(it);
    if (typed) model_res = want;
    verdict_q = {verdict_q, model_res};
  endtask

  // Stop issuing and wait until every owed result has come back.
  task automatic settle_block();
    start <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0 || busy) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_register(dfaet_pkg::reg_e sel, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == dfaet_pkg::REG_START) begin
      start_q     = value[7:0];
      present_q   = start_q;
      word_dead_q = 1'b0;
    end else begin
      edge_count_q = value[10:0];
    end
    @(posedge clk_i);
  endtask

  // Compare each result transaction with the oldest one owed.
  always @(posedge clk_i) begin : check_results
    dfaet_pkg::res_t want;
    if (rst_ni && result_valid_o) begin
      if (verdict_q.size() == 0) begin
        flag_mismatch("result transaction with nothing pending");
      end else begin
        want = verdict_q.pop_front();
        if (alive_o !== want.alive)
          flag_mismatch($sformatf("alive: got %b, expected %b", alive_o, want.alive));
        if (word_done_o !== want.word_done)
          flag_mismatch($sformatf("word_done: got %b, expected %b", word_done_o,
                                  want.word_done));
        if (accepted_o !== want.accepted)
          flag_mismatch($sformatf("accepted: got %b, expected %b", accepted_o,
                                  want.accepted));
        if (current_o !== want.current)
          flag_mismatch($sformatf("current: got %h, expected %h", current_o, want.current));
      end
    end
  end

  initial begin
    cmd_item_t       it;
    dfaet_pkg::res_t none;
    int unsigned     rand_count;
    int unsigned     prefix;
    int unsigned     span_cap;
    int unsigned     roll;
    int unsigned     new_count;
    int unsigned     waited;
    int unsigned     e;

    none         = '0;
    calm_stretch = 1'b0;
    mismatch_cnt = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset status, field extremes, every command, the special cases.
    add_cmd(dfaet_pkg::CMD_NOP, 10'h3FF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1,
            dfaet_pkg::res_t'{1'b1, 1'b0, 1'b0, 8'h00});
    // With no valid edges the first letter kills the word at once.
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1,
            dfaet_pkg::res_t'{1'b0, 1'b1, 1'b0, 8'h00});
    add_cmd(dfaet_pkg::CMD_FINAL, 10'h000, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1,
            dfaet_pkg::res_t'{1'b1, 1'b0, 1'b0, 8'h00});
    add_cmd(dfaet_pkg::CMD_FINAL, 10'h3FF, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1,
            dfaet_pkg::res_t'{1'b1, 1'b0, 1'b0, 8'h00});
    add_cmd(dfaet_pkg::CMD_EDGE, 10'h000, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1,
            dfaet_pkg::res_t'{1'b1, 1'b0, 1'b0, 8'h00});
    add_cmd(dfaet_pkg::CMD_EDGE, 10'h001, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1,
            dfaet_pkg::res_t'{1'b1, 1'b0, 1'b0, 8'h00});
    add_cmd(dfaet_pkg::CMD_EDGE, 10'h002, 8'h00, 8'h00, 8'h01, 1'b0, 1'b1, 1'b1,
            dfaet_pkg::res_t'{1'b1, 1'b0, 1'b0, 8'h00});
    // Same source and letter as entry 0, so it must never be taken.
    add_cmd(dfaet_pkg::CMD_EDGE, 10'h003, 8'h00, 8'hFF, 8'h05, 1'b1, 1'b0, 1'b1,
            dfaet_pkg::res_t'{1'b1, 1'b0, 1'b0, 8'h00});
    add_cmd(dfaet_pkg::CMD_EDGE, 10'h3FF, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 1'b1,
            dfaet_pkg::res_t'{1'b1, 1'b0, 1'b0, 8'h00});
    add_cfg(dfaet_pkg::REG_COUNT, 32'd4);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h155, 8'hAA, 8'hFF, 8'h55, 1'b1, 1'b0, 1'b0, none);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h2AA, 8'h55, 8'h00, 8'hAA, 1'b0, 1'b1, 1'b0, none);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b0, none);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, none);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'h55, 8'h00, 1'b0, 1'b0, 1'b0, none);
    // A non-letter command in a dead word reports the dead status.
    add_cmd(dfaet_pkg::CMD_FINAL, 10'h000, 8'h01, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1,
            dfaet_pkg::res_t'{1'b0, 1'b0, 1'b0, 8'h01});
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, none);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, none);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, none);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, none);
    // Writing the start state aborts the word in progress.
    add_cfg(dfaet_pkg::REG_START, 32'hFF);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, none);
    add_cmd(dfaet_pkg::CMD_FINAL, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, none);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, none);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, none);
    add_cfg(dfaet_pkg::REG_COUNT, 32'd0);
    add_cmd(dfaet_pkg::CMD_LETTER, 10'h000, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b1,
            dfaet_pkg::res_t'{1'b0, 1'b1, 1'b0, 8'hFF});

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        settle_block();
        write_register(directed_rows[r].sel, directed_rows[r].value);
      end else begin
        issue_command(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // Random phases: small state and letter pools keep words alive across many letters.
    rand_count = 0;
    while (rand_count < RANDOM_ITEMS) begin
      settle_block();
      foreach (state_pool[s]) state_pool[s] = 8'($urandom);
      foreach (letter_pool[l]) letter_pool[l] = 8'($urandom);
      if ($urandom_range(0, 99) < 15) state_pool[0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      write_register(dfaet_pkg::REG_START, 32'(state_pool[0]));

      // Load a few edges, growing the loaded prefix or rewriting entries near the top.
      repeat ($urandom_range(3, 8)) begin
        prefix   = loaded_prefix();
        span_cap = (prefix < LIVE_CAP) ? prefix : LIVE_CAP;
        if (prefix < EDGE_SLOTS && $urandom_range(0, 1) == 1)
          it = pool_edge(10'(prefix));
        else
          it = pool_edge(10'($urandom_range(0, span_cap - 1)));
        issue_command(it, 1'b0, none);
        rand_count++;
      end

      // Only loaded entries may fall inside the valid range.
      settle_block();
      prefix   = loaded_prefix();
      span_cap = (prefix < LIVE_CAP) ? prefix : LIVE_CAP;
      roll     = $urandom_range(0, 99);
      if (roll < 10 || span_cap == 0)
        new_count = 0;
      else if (roll < 70)
        new_count = span_cap;
      else
        new_count = $urandom_range(1, span_cap);
      write_register(dfaet_pkg::REG_COUNT, 32'(new_count));

      repeat ($urandom_range(20, 50)) begin
        calm_stretch = (rand_count >= 200 && rand_count < 320);
        it = random_command();
        issue_command(it, 1'b0, none);
        if (it.cmd != dfaet_pkg::CMD_NOP) rand_count++;
      end
    end
    calm_stretch = 1'b0;

    // A count at the table size and beyond: entries 0 to 3 give every pool state an
    // edge on one letter, so each scan stops inside the loaded entries.
    settle_block();
    foreach (state_pool[s]) state_pool[s] = 8'($urandom);
    letter_pool[0] = 8'($urandom);
    for (e = 0; e < 4; e++) begin
      it     = pool_edge(10'(e));
      it.src = state_pool[e];
      it.sym = letter_pool[0];
      it.dst = state_pool[(e + 1) % 4];
      issue_command(it, 1'b0, none);
    end
    settle_block();
    write_register(dfaet_pkg::REG_START, 32'(state_pool[0]));
    write_register(dfaet_pkg::REG_COUNT, 32'(EDGE_SLOTS));
    repeat (12) issue_command(ring_command(), 1'b0, none);

    settle_block();
    write_register(dfaet_pkg::REG_COUNT, 32'h7FF);
    repeat (12) issue_command(ring_command(), 1'b0, none);

    // Drain the last transactions, then watch a while longer for stray results.
    start <= 1'b0;
    waited = 0;
    while (verdict_q.size() != 0 && waited < 4 * TAIL_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (verdict_q.size() != 0)
      flag_mismatch($sformatf("%0d transactions never produced a result", verdict_q.size()));

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
